FILE: design/rrp_pkg.sv
`timescale 1ns / 1ps
package rrp_pkg;

	localparam int POS_BITS     = 16;
	localparam int SLOT_COUNT   = 1 << POS_BITS;
	localparam int SIZE_W       = POS_BITS + 1;

	localparam int RANGE_SIZE_W = 17;
	localparam int START_W      = 64;
	localparam int SHIFT_W      = 6;
	localparam int RND_W        = 32;
	localparam int ADDR_W       = 64;
	localparam int POSITION_W   = 16;
	localparam int REMAINING_W  = 17;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 64;
	localparam int CMP_W        = (RANGE_SIZE_W > SIZE_W) ? RANGE_SIZE_W : SIZE_W;

	// swap table entry: {epoch tag, position}
	localparam int EPOCH_BITS   = 8;
	localparam int ENTRY_W      = EPOCH_BITS + POS_BITS;

	// remainder unit: quotient bits retired per cycle
	localparam int DIV_BITS     = 2;
	localparam int DIV_STEPS    = RND_W / DIV_BITS;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

	localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_SIZE    = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_START_ADDRESS = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SHIFT    = CFG_INDEX_W'(2);

	localparam logic OP_DRAW    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef enum logic [1:0] {
		RD_CURSOR,
		RD_PICK,
		RD_ZERO
	} rd_sel_t;

	typedef struct packed {
		logic    load_item;
		logic    restart;
		logic    set_spent;
		logic    take_last;
		logic    div_start;
		logic    cap_moved;
		logic    take_pick;
		logic    clear_step;
		logic    shift;
		logic    load_out;
		rd_sel_t rd_sel;
	} rrp_cmd_t;

	typedef struct packed {
		logic op_restart;
		logic exhausted;
		logic cursor_zero;
		logic epoch_full;
		logic div_done;
		logic clear_last;
		logic out_free;
	} rrp_status_t;

endpackage

FILE: design/rrp_ram.sv
`timescale 1ns / 1ps
module rrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/rrp_ctrl.sv
`timescale 1ns / 1ps
module rrp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rrp_pkg::rrp_status_t status,
	output rrp_pkg::rrp_cmd_t    cmd
);
	import rrp_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_RESTART,
		ST_CAP,
		ST_DIV,
		ST_TAKE_PICK,
		ST_TAKE_LAST,
		ST_SHIFT,
		ST_PUT
	} state_t;

	state_t state_q;
	logic   restart_pend_q;

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_CURSOR;
		in_stall   = (state_q != ST_IDLE);
		unique case (state_q)
			ST_CLEAR:     cmd.clear_step = 1'b1;
			ST_IDLE:      cmd.load_item  = in_valid;
			ST_DECODE: begin
				if (!status.op_restart) begin
					if (status.exhausted) begin
						cmd.set_spent = 1'b1;
					end else if (status.cursor_zero) begin
						cmd.rd_sel = RD_ZERO;
					end else begin
						cmd.div_start = 1'b1;
						cmd.rd_sel    = RD_CURSOR;
					end
				end
			end
			ST_RESTART:   cmd.restart   = 1'b1;
			ST_CAP:       cmd.cap_moved = 1'b1;
			ST_DIV: begin
				if (status.div_done) begin
					cmd.rd_sel = RD_PICK;
				end
			end
			ST_TAKE_PICK: cmd.take_pick = 1'b1;
			ST_TAKE_LAST: cmd.take_last = 1'b1;
			ST_SHIFT:     cmd.shift     = 1'b1;
			ST_PUT:       cmd.load_out  = status.out_free;
			default:      cmd.rd_sel    = RD_CURSOR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			restart_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clear_last) begin
						state_q        <= restart_pend_q ? ST_RESTART : ST_IDLE;
						restart_pend_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (status.op_restart) begin
						if (status.epoch_full) begin
							state_q        <= ST_CLEAR;
							restart_pend_q <= 1'b1;
						end else begin
							state_q <= ST_RESTART;
						end
					end else if (status.exhausted) begin
						state_q <= ST_PUT;
					end else if (status.cursor_zero) begin
						state_q <= ST_TAKE_LAST;
					end else begin
						state_q <= ST_CAP;
					end
				end
				ST_RESTART:   state_q <= ST_PUT;
				ST_CAP:       state_q <= ST_DIV;
				ST_DIV: begin
					if (status.div_done) begin
						state_q <= ST_TAKE_PICK;
					end
				end
				ST_TAKE_PICK: state_q <= ST_SHIFT;
				ST_TAKE_LAST: state_q <= ST_SHIFT;
				ST_SHIFT:     state_q <= ST_PUT;
				ST_PUT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: design/rrp_dp.sv
`timescale 1ns / 1ps
module rrp_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [rrp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rrp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             op,
	input  logic [rrp_pkg::RND_W-1:0]        random_value,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic [rrp_pkg::ADDR_W-1:0]       address,
	output logic                             address_carry,
	output logic [rrp_pkg::POSITION_W-1:0]   position,
	output logic                             finished,
	output logic [rrp_pkg::REMAINING_W-1:0]  remaining,
	input  rrp_pkg::rrp_cmd_t                cmd,
	output rrp_pkg::rrp_status_t             status
);
	import rrp_pkg::*;

	logic [RANGE_SIZE_W-1:0] range_size_q;
	logic [START_W-1:0]      start_address_q;
	logic [SHIFT_W-1:0]      step_shift_q;

	logic                    op_q;
	logic [POS_BITS-1:0]     cursor_q;
	logic                    exhausted_q;
	logic [EPOCH_BITS-1:0]   epoch_q;
	logic [POS_BITS-1:0]     clear_cnt_q;

	logic [POS_BITS-1:0]     div_rem_q;
	logic [RND_W-1:0]        div_num_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;
	logic [POS_BITS:0]       trial;
	logic [POS_BITS-1:0]     rem_nx;
	logic [RND_W-1:0]        num_nx;

	logic [POS_BITS-1:0]     rd_addr;
	logic [POS_BITS-1:0]     rd_addr_s1;
	logic [ENTRY_W-1:0]      rdata;
	logic [POS_BITS-1:0]     slot_val;
	logic                    mem_we;
	logic [POS_BITS-1:0]     mem_waddr;
	logic [ENTRY_W-1:0]      mem_wdata;
	logic [POS_BITS-1:0]     moved_q;

	logic [CMP_W-1:0]        size_ext;
	logic [SIZE_W-1:0]       size_eff;

	logic [POS_BITS-1:0]     res_pos_q;
	logic                    res_fin_q;
	logic [SIZE_W-1:0]       res_rem_q;
	logic                    res_live_q;
	logic [ADDR_W-1:0]       offset_q;
	logic [ADDR_W:0]         sum;

	logic                    out_valid_q;
	logic [ADDR_W-1:0]       out_address_q;
	logic                    out_carry_q;
	logic [POSITION_W-1:0]   out_position_q;
	logic                    out_finished_q;
	logic [REMAINING_W-1:0]  out_remaining_q;

	// sizes above the slot count are clamped
	always_comb begin
		size_ext = CMP_W'(range_size_q);
		size_eff = (size_ext > CMP_W'(SLOT_COUNT)) ? SIZE_W'(SLOT_COUNT) : SIZE_W'(size_ext);
	end

	// restoring remainder of random word by cursor, DIV_BITS bits per cycle
	always_comb begin
		rem_nx = div_rem_q;
		num_nx = div_num_q;
		trial  = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial  = {rem_nx, num_nx[RND_W-1]};
			num_nx = {num_nx[RND_W-2:0], 1'b0};
			if (trial >= {1'b0, cursor_q}) begin
				trial = trial - {1'b0, cursor_q};
			end
			rem_nx = trial[POS_BITS-1:0];
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_CURSOR: rd_addr = cursor_q;
			RD_PICK:   rd_addr = div_rem_q;
			RD_ZERO:   rd_addr = '0;
			default:   rd_addr = cursor_q;
		endcase
	end

	// entry counts only if tagged with the current epoch
	assign slot_val = (rdata[ENTRY_W-1 -: EPOCH_BITS] == epoch_q) ? rdata[POS_BITS-1:0]
	                                                               : rd_addr_s1;

	assign mem_we    = cmd.clear_step | cmd.take_pick;
	assign mem_waddr = cmd.clear_step ? clear_cnt_q : div_rem_q;
	assign mem_wdata = cmd.clear_step ? '0 : {epoch_q, moved_q};

	rrp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_swap_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign sum = {1'b0, start_address_q} + {1'b0, offset_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_size_q    <= RANGE_SIZE_W'(1);
			start_address_q <= '0;
			step_shift_q    <= '0;
			cursor_q        <= '0;
			exhausted_q     <= 1'b1;
			epoch_q         <= '0;
			clear_cnt_q     <= '0;
			div_cnt_q       <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					CFG_RANGE_SIZE:    range_size_q    <= cfg_data[RANGE_SIZE_W-1:0];
					CFG_START_ADDRESS: start_address_q <= cfg_data[START_W-1:0];
					CFG_STEP_SHIFT:    step_shift_q    <= cfg_data[SHIFT_W-1:0];
					default:           range_size_q    <= range_size_q;
				endcase
			end
			if (cmd.clear_step) begin
				clear_cnt_q <= clear_cnt_q + 1'b1;
			end
			if (cmd.restart) begin
				epoch_q <= status.epoch_full ? EPOCH_BITS'(1) : epoch_q + 1'b1;
				if (size_eff == '0) begin
					cursor_q    <= '0;
					exhausted_q <= 1'b1;
				end else begin
					cursor_q    <= POS_BITS'(size_eff - 1'b1);
					exhausted_q <= 1'b0;
				end
			end
			if (cmd.take_last) begin
				exhausted_q <= 1'b1;
			end
			if (cmd.take_pick) begin
				cursor_q <= cursor_q - 1'b1;
			end
			if (cmd.div_start) begin
				div_cnt_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_addr;
		if (cmd.load_item) begin
			op_q      <= op;
			div_num_q <= random_value;
		end
		if (cmd.div_start) begin
			div_rem_q <= '0;
		end else if (div_cnt_q != '0) begin
			div_rem_q <= rem_nx;
			div_num_q <= num_nx;
		end
		if (cmd.cap_moved) begin
			moved_q <= slot_val;
		end
		if (cmd.restart) begin
			res_pos_q  <= '0;
			res_fin_q  <= 1'b0;
			res_rem_q  <= size_eff;
			res_live_q <= 1'b0;
		end
		if (cmd.set_spent) begin
			res_pos_q  <= '0;
			res_fin_q  <= 1'b1;
			res_rem_q  <= '0;
			res_live_q <= 1'b0;
		end
		if (cmd.take_last) begin
			res_pos_q  <= slot_val;
			res_fin_q  <= 1'b1;
			res_rem_q  <= '0;
			res_live_q <= 1'b1;
		end
		if (cmd.take_pick) begin
			res_pos_q  <= slot_val;
			res_fin_q  <= 1'b0;
			res_rem_q  <= SIZE_W'(cursor_q);
			res_live_q <= 1'b1;
		end
		if (cmd.shift) begin
			offset_q <= ADDR_W'(res_pos_q) << step_shift_q;
		end
		if (cmd.load_out) begin
			out_address_q   <= res_live_q ? sum[ADDR_W-1:0] : '0;
			out_carry_q     <= res_live_q ? sum[ADDR_W] : 1'b0;
			out_position_q  <= POSITION_W'(res_pos_q);
			out_finished_q  <= res_fin_q;
			out_remaining_q <= REMAINING_W'(res_rem_q);
		end
	end

	always_comb begin
		status.op_restart  = (op_q == OP_RESTART);
		status.exhausted   = exhausted_q;
		status.cursor_zero = (cursor_q == '0);
		status.epoch_full  = &epoch_q;
		status.div_done    = (div_cnt_q == '0);
		status.clear_last  = &clear_cnt_q;
		status.out_free    = !out_valid_q || !out_stall;
	end

	assign out_valid     = out_valid_q;
	assign address       = out_address_q;
	assign address_carry = out_carry_q;
	assign position      = out_position_q;
	assign finished      = out_finished_q;
	assign remaining     = out_remaining_q;

	a_pick_below_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_pick |-> (div_rem_q < cursor_q))
		else $error("picked slot not below cursor");

	a_cursor_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_pick |=> (cursor_q == POS_BITS'($past(cursor_q) - 1'b1)))
		else $error("cursor did not step down after a draw");

	a_last_exhausts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_last |=> exhausted_q)
		else $error("last draw left range live");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free)
		else $error("result overwrote a pending transfer");

endmodule

FILE: design/random_range_permutation_top.sv
`timescale 1ns / 1ps
// Hands out every position of a configured range exactly once in random order (lazy
// Fisher-Yates over a 64K-entry swap RAM) and returns start_address + (position << step_shift).
// A draw other than the last takes one swap-RAM read of the cursor slot, a pass of the remainder
// unit, which retires two bits of the 32-bit random word per cycle, one read of the picked slot
// and one write. Valid marks are epoch tags stored with each RAM entry; after reset, and on each
// restart that finds the epoch tag at 255, a clearing pass writes all 65536 entries, one a cycle,
// with input held stalled.
// The next item is taken while a finished result still waits in the output register.
// The user must write configuration only while the block is idle; the block does not enforce it.
module random_range_permutation_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [rrp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rrp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             op,
	input  logic [rrp_pkg::RND_W-1:0]        random_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rrp_pkg::ADDR_W-1:0]       address,
	output logic                             address_carry,
	output logic [rrp_pkg::POSITION_W-1:0]   position,
	output logic                             finished,
	output logic [rrp_pkg::REMAINING_W-1:0]  remaining
);
	import rrp_pkg::*;

	rrp_cmd_t    cmd;
	rrp_status_t status;

	rrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rrp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.op            (op),
		.random_value  (random_value),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.address       (address),
		.address_carry (address_carry),
		.position      (position),
		.finished      (finished),
		.remaining     (remaining),
		.cmd           (cmd),
		.status        (status)
	);

endmodule
